[sv/bfh_pkg.sv]
// shared types and constants for the back/forward history stacks
// used by bfh_ctrl, bfh_dp and back_forward_history_stacks; no dependencies
`default_nettype none

package bfh_pkg;

    // fixed field widths on the stream ports
    localparam int PAGE_W     = 32;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 1;

    // operation codes carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_VISIT = 2'd0,
        FUNC_BACK  = 2'd1,
        FUNC_NEXT  = 2'd2,
        FUNC_LIST  = 2'd3
    } t_func;

    // navigation status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_PREV = 2'd1,
        STAT_NO_NEXT = 2'd2
    } t_status;

    // result kind carried on the output tuser
    typedef enum logic {
        KIND_NAV  = 1'b0,
        KIND_LIST = 1'b1
    } t_kind;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_in;
        logic op_eval;
        logic visit;
        logic back_move;
        logic next_move;
        logic load_back;
        logic load_fwd;
        logic emit_stat;
        logic list_start;
        logic list_read;
        logic list_emit;
        logic emit_cur;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_func func;
        logic  back_empty;
        logic  fwd_empty;
        logic  cur_zero;
        logic  list_more;
        logic  out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[sv/bfh_dp.sv]
// datapath of the history stacks: stores, counters, current page, output register
// depends on bfh_pkg; driven by the command struct from bfh_ctrl
`default_nettype none

module bfh_dp
    import bfh_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32,
    parameter int PAGE_ID_BITS  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic [IN_USER_W-1:0]  i_in_user,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [OUT_DATA_W-1:0]      o_out_data,
    output logic [OUT_USER_W-1:0]      o_out_user,
    output logic                       o_out_last
);

    localparam int PW = (PAGE_ID_BITS < PAGE_W) ? PAGE_ID_BITS : PAGE_W;
    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = CW + 1;

    // ring index wrap for sums below twice the depth
    function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] s);
        if (s >= SW'(HISTORY_DEPTH)) begin
            wrap_idx = IW'(s - SW'(HISTORY_DEPTH));
        end else begin
            wrap_idx = IW'(s);
        end
    endfunction

    // stores
    logic [PW-1:0] r_back_mem [HISTORY_DEPTH];
    logic [PW-1:0] r_fwd_mem  [HISTORY_DEPTH];
    logic [PW-1:0] r_back_rdata;
    logic [PW-1:0] r_fwd_rdata;

    // control state
    logic [IW-1:0] r_back_bottom, n_back_bottom;
    logic [CW-1:0] r_back_count,  n_back_count;
    logic [CW-1:0] r_fwd_count,   n_fwd_count;
    logic [CW-1:0] r_list_idx,    n_list_idx;
    logic [PW-1:0] r_cur,         n_cur;
    logic          r_out_valid,   n_out_valid;

    // latched item and result payload
    t_func         r_func;
    logic [PW-1:0] r_pid;
    t_status       r_status;
    t_kind         r_out_kind;
    logic [PW-1:0] r_out_page;
    logic          r_out_has_back;
    logic          r_out_has_fwd;
    t_status       r_out_status;
    logic          r_out_last;

    // memory port controls
    logic          back_we, fwd_we, back_re, fwd_re;
    logic [IW-1:0] back_waddr, back_raddr, fwd_waddr, fwd_raddr;
    logic [PW-1:0] back_wdata, fwd_wdata;

    logic          back_full, fwd_full, pid_nz, cur_nz;
    logic          out_free, load_out;

    assign back_full = (r_back_count == CW'(HISTORY_DEPTH));
    assign fwd_full  = (r_fwd_count == CW'(HISTORY_DEPTH));
    assign pid_nz    = (r_pid != '0);
    assign cur_nz    = (r_cur != '0);
    assign out_free  = !r_out_valid || i_out_ready;
    assign load_out  = i_cmd.emit_stat || i_cmd.list_emit || i_cmd.emit_cur;

    // next state of counters, current page and memory ports
    always_comb begin
        n_back_bottom = r_back_bottom;
        n_back_count  = r_back_count;
        n_fwd_count   = r_fwd_count;
        n_list_idx    = r_list_idx;
        n_cur         = r_cur;
        back_we       = 1'b0;
        fwd_we        = 1'b0;
        back_re       = 1'b0;
        fwd_re        = 1'b0;
        back_wdata    = r_cur;
        fwd_wdata     = r_cur;
        fwd_waddr     = IW'(r_fwd_count);
        fwd_raddr     = IW'(r_fwd_count - CW'(1));
        back_raddr    = wrap_idx(SW'(r_back_bottom) + SW'(r_list_idx));
        // push slot, or the oldest slot when the ring is full
        if (back_full) begin
            back_waddr = r_back_bottom;
        end else begin
            back_waddr = wrap_idx(SW'(r_back_bottom) + SW'(r_back_count));
        end

        // back push shared by visit and next
        if ((i_cmd.visit && pid_nz && cur_nz) || i_cmd.next_move) begin
            back_we = 1'b1;
            if (back_full) begin
                n_back_bottom = wrap_idx(SW'(r_back_bottom) + SW'(1));
            end else begin
                n_back_count = r_back_count + CW'(1);
            end
        end

        if (i_cmd.visit && pid_nz) begin
            n_cur       = r_pid;
            n_fwd_count = '0;
        end

        // back: push current to forward, pop back stack
        if (i_cmd.back_move) begin
            fwd_we       = 1'b1;
            back_re      = 1'b1;
            back_raddr   = wrap_idx(SW'(r_back_bottom) + SW'(r_back_count) - SW'(1));
            n_back_count = r_back_count - CW'(1);
            if (fwd_full) begin
                fwd_waddr = IW'(HISTORY_DEPTH - 1);
            end else begin
                n_fwd_count = r_fwd_count + CW'(1);
            end
        end

        // next: pop forward stack
        if (i_cmd.next_move) begin
            fwd_re      = 1'b1;
            n_fwd_count = r_fwd_count - CW'(1);
        end

        if (i_cmd.load_back) begin
            n_cur = r_back_rdata;
        end
        if (i_cmd.load_fwd) begin
            n_cur = r_fwd_rdata;
        end

        // list walk
        if (i_cmd.list_start) begin
            n_list_idx = '0;
        end
        if (i_cmd.list_read) begin
            back_re = 1'b1;
        end
        if (i_cmd.list_emit) begin
            n_list_idx = r_list_idx + CW'(1);
        end

        // output register
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_bottom <= '0;
            r_back_count  <= '0;
            r_fwd_count   <= '0;
            r_list_idx    <= '0;
            r_cur         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_back_bottom <= n_back_bottom;
            r_back_count  <= n_back_count;
            r_fwd_count   <= n_fwd_count;
            r_list_idx    <= n_list_idx;
            r_cur         <= n_cur;
            r_out_valid   <= n_out_valid;
        end
    end

    // stores with registered read
    always_ff @(posedge i_clk) begin
        if (back_we) begin
            r_back_mem[back_waddr] <= back_wdata;
        end
        if (back_re) begin
            r_back_rdata <= r_back_mem[back_raddr];
        end
        if (fwd_we) begin
            r_fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        if (fwd_re) begin
            r_fwd_rdata <= r_fwd_mem[fwd_raddr];
        end
    end

    // item latch, status and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func <= t_func'(i_in_user);
            r_pid  <= PW'(i_in_data);
        end
        if (i_cmd.op_eval) begin
            if (r_func == FUNC_BACK && r_back_count == '0) begin
                r_status <= STAT_NO_PREV;
            end else if (r_func == FUNC_NEXT && r_fwd_count == '0) begin
                r_status <= STAT_NO_NEXT;
            end else begin
                r_status <= STAT_OK;
            end
        end
        if (load_out) begin
            r_out_has_back <= (r_back_count != '0);
            r_out_has_fwd  <= (r_fwd_count != '0);
        end
        if (i_cmd.emit_stat) begin
            r_out_kind   <= KIND_NAV;
            r_out_page   <= r_cur;
            r_out_status <= r_status;
            r_out_last   <= 1'b1;
        end
        if (i_cmd.list_emit) begin
            r_out_kind   <= KIND_LIST;
            r_out_page   <= r_back_rdata;
            r_out_status <= STAT_OK;
            r_out_last   <= (r_list_idx + CW'(1) == r_back_count) && !cur_nz;
        end
        if (i_cmd.emit_cur) begin
            r_out_kind   <= KIND_LIST;
            r_out_page   <= r_cur;
            r_out_status <= STAT_OK;
            r_out_last   <= 1'b1;
        end
    end

    // status to controller
    assign o_stat.func       = r_func;
    assign o_stat.back_empty = (r_back_count == '0);
    assign o_stat.fwd_empty  = (r_fwd_count == '0);
    assign o_stat.cur_zero   = !cur_nz;
    assign o_stat.list_more  = (r_list_idx < r_back_count);
    assign o_stat.out_free   = out_free;

    // result stream
    assign o_out_valid = r_out_valid;
    assign o_out_data  = {4'b0000, r_out_status, r_out_has_fwd, r_out_has_back,
                          PAGE_W'(r_out_page)};
    assign o_out_user  = r_out_kind;
    assign o_out_last  = r_out_last;

    // stack counts stay within the store depth
    a_back_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_back_count <= CW'(HISTORY_DEPTH))
        else $error("back stack count beyond depth");

    a_fwd_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_count <= CW'(HISTORY_DEPTH))
        else $error("forward stack count beyond depth");

    // a real visit always empties the forward stack
    a_visit_clears_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.visit && pid_nz) |=> (r_fwd_count == '0))
        else $error("forward stack not cleared by visit");

    // a result is never loaded over one that is still waiting
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire

[sv/bfh_ctrl.sv]
// controller state machine for the history stacks
// depends on bfh_pkg; issues commands to bfh_dp and reads its status
`default_nettype none

module bfh_ctrl
    import bfh_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OP   = 7'b0000010,
        S_LOAD = 7'b0000100,
        S_STAT = 7'b0001000,
        S_LRD  = 7'b0010000,
        S_LEM  = 7'b0100000,
        S_LCUR = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // next state and command decode
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_OP;
                end
            end
            S_OP: begin
                o_cmd.op_eval = 1'b1;
                unique case (i_stat.func)
                    FUNC_VISIT: begin
                        o_cmd.visit = 1'b1;
                        n_state     = S_STAT;
                    end
                    FUNC_BACK: begin
                        if (i_stat.back_empty) begin
                            n_state = S_STAT;
                        end else begin
                            o_cmd.back_move = 1'b1;
                            n_state         = S_LOAD;
                        end
                    end
                    FUNC_NEXT: begin
                        if (i_stat.fwd_empty) begin
                            n_state = S_STAT;
                        end else begin
                            o_cmd.next_move = 1'b1;
                            n_state         = S_LOAD;
                        end
                    end
                    default: begin
                        o_cmd.list_start = 1'b1;
                        n_state          = S_LRD;
                    end
                endcase
            end
            S_LOAD: begin
                if (i_stat.func == FUNC_BACK) begin
                    o_cmd.load_back = 1'b1;
                end else begin
                    o_cmd.load_fwd = 1'b1;
                end
                n_state = S_STAT;
            end
            S_STAT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_stat = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_LRD: begin
                if (i_stat.list_more) begin
                    o_cmd.list_read = 1'b1;
                    n_state         = S_LEM;
                end else if (!i_stat.cur_zero || i_stat.back_empty) begin
                    n_state = S_LCUR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LEM: begin
                if (i_stat.out_free) begin
                    o_cmd.list_emit = 1'b1;
                    n_state         = S_LRD;
                end
            end
            S_LCUR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_cur = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a move is only issued on a non-empty stack
    a_back_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.back_move |-> !i_stat.back_empty)
        else $error("back move on empty stack");

    a_next_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.next_move |-> !i_stat.fwd_empty)
        else $error("next move on empty stack");

    // every stack move is followed by loading the current page
    a_move_then_load : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.back_move || o_cmd.next_move) |=> (o_cmd.load_back || o_cmd.load_fwd))
        else $error("stack move without page load");

endmodule

`default_nettype wire

[sv/back_forward_history_stacks.sv]
// Back/forward browser history held as a back ring, a forward stack and a current
// page. Commands arrive one at a time: a visit or failed back/next passes the op
// and status states; a successful back or next also passes a load state for the
// registered read of the popped page from its stack memory. A list command walks
// the back stack from the oldest entry up, one back store read per entry, then
// gives the current page unless it is zero and the back stack is not; the last
// result carries tlast. The next command is taken once the previous one's final
// result is in the output register, which holds it until the sink takes it.
// top level; depends on bfh_pkg, bfh_ctrl and bfh_dp
`default_nettype none

module back_forward_history_stacks
    import bfh_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32,
    parameter int PAGE_ID_BITS  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] page_id
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,  // [1:0] func
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [31:0] page, [32] has_back,
                                                      // [33] has_forward, [35:34] status
    output logic [OUT_USER_W-1:0]      m_axis_tuser,  // [0] kind
    output logic                       m_axis_tlast
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // command sequencing
    bfh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // stacks and result register
    bfh_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PAGE_ID_BITS  (PAGE_ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[verif/back_forward_history_stacks_tb.sv]
// testbench for back_forward_history_stacks: directed, stack-filling and random commands
// checked against a scoreboard that tracks the back ring, forward stack and current page
// depends on bfh_pkg and back_forward_history_stacks
`timescale 1ns / 100ps

module back_forward_history_stacks_tb
    import bfh_pkg::*;
();

    localparam int HIST_DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 20;

    // one expected output item
    typedef struct {
        t_kind             kind;
        logic [PAGE_W-1:0] page;
        logic              has_back;
        logic              has_fwd;
        t_status           status;
        logic              last;
    } t_hist_reply;

    // tracks navigation state and checks every output item in order
    class nav_history_checker;
        logic [PAGE_W-1:0] back_ring [HIST_DEPTH];
        int unsigned       ring_oldest;
        int unsigned       back_len;
        logic [PAGE_W-1:0] fwd_pages [HIST_DEPTH];
        int unsigned       fwd_len;
        logic [PAGE_W-1:0] cur_page;
        t_hist_reply       reply_q[$];
        int                errors;
        int                checked;

        function new();
            ring_oldest = 0;
            back_len    = 0;
            fwd_len     = 0;
            cur_page    = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        function int pending();
            return reply_q.size();
        endfunction

        // a full ring overwrites its oldest entry
        function void push_back_page(logic [PAGE_W-1:0] p);
            if (back_len >= HIST_DEPTH) begin
                back_ring[ring_oldest] = p;
                ring_oldest = (ring_oldest + 1) % HIST_DEPTH;
            end else begin
                back_ring[(ring_oldest + back_len) % HIST_DEPTH] = p;
                back_len++;
            end
        endfunction

        function void add_reply(t_kind kind, logic [PAGE_W-1:0] page, t_status status,
                                logic last);
            t_hist_reply r;
            r.kind     = kind;
            r.page     = page;
            r.has_back = (back_len != 0);
            r.has_fwd  = (fwd_len != 0);
            r.status   = status;
            r.last     = last;
            reply_q.push_back(r);
        endfunction

        function void note_command(t_func func, logic [PAGE_W-1:0] page_id);
            t_status status;
            status = STAT_OK;
            case (func)
                FUNC_VISIT: begin
                    // page zero means none and leaves the history alone
                    if (page_id != '0) begin
                        if (cur_page != '0) push_back_page(cur_page);
                        cur_page = page_id;
                        fwd_len  = 0;
                    end
                end
                FUNC_BACK: begin
                    if (back_len == 0) begin
                        status = STAT_NO_PREV;
                    end else begin
                        if (fwd_len >= HIST_DEPTH) fwd_pages[HIST_DEPTH-1] = cur_page;
                        else fwd_pages[fwd_len++] = cur_page;
                        back_len--;
                        cur_page = back_ring[(ring_oldest + back_len) % HIST_DEPTH];
                    end
                end
                FUNC_NEXT: begin
                    if (fwd_len == 0) begin
                        status = STAT_NO_NEXT;
                    end else begin
                        push_back_page(cur_page);
                        fwd_len--;
                        cur_page = fwd_pages[fwd_len];
                    end
                end
                default: begin
                    // oldest back entry first, current page last
                    for (int i = 0; i < back_len; i++)
                        add_reply(KIND_LIST, back_ring[(ring_oldest + i) % HIST_DEPTH],
                                  STAT_OK, (i + 1 == back_len) && (cur_page == '0));
                    if (cur_page != '0 || back_len == 0)
                        add_reply(KIND_LIST, cur_page, STAT_OK, 1'b1);
                end
            endcase
            if (func != FUNC_LIST) add_reply(KIND_NAV, cur_page, status, 1'b1);
        endfunction

        function void check_result(logic kind, logic [PAGE_W-1:0] page, logic has_back,
                                   logic has_fwd, logic [1:0] status, logic last);
            t_hist_reply r;
            checked++;
            if (reply_q.size() == 0) begin
                $error("unexpected output item: kind %0d page %h", kind, page);
                errors++;
                return;
            end
            r = reply_q.pop_front();
            if (r.kind !== kind) begin
                $error("kind: expected %0d, got %0d", r.kind, kind);
                errors++;
            end
            if (r.page !== page) begin
                $error("page: expected %h, got %h", r.page, page);
                errors++;
            end
            if (r.has_back !== has_back) begin
                $error("has_back: expected %0d, got %0d", r.has_back, has_back);
                errors++;
            end
            if (r.has_fwd !== has_fwd) begin
                $error("has_forward: expected %0d, got %0d", r.has_fwd, has_fwd);
                errors++;
            end
            if (r.status !== status) begin
                $error("status: expected %0d, got %0d", r.status, status);
                errors++;
            end
            if (r.last !== last) begin
                $error("last: expected %0d, got %0d", r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [31:0] page_id
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // [1:0] func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [31:0] page, [32] has_back,
                                                // [33] has_forward, [35:34] status
    logic [OUT_USER_W-1:0] m_axis_tuser;        // [0] kind
    logic                  m_axis_tlast;

    nav_history_checker hist = new();
    int burst_left = 0;
    int func_seen [4] = '{0, 0, 0, 0};
    int sink_mode = 0;
    int sink_left = 0;

    always #5 i_clk = ~i_clk;

    back_forward_history_stacks #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .PAGE_ID_BITS (PAGE_W)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // sink readiness switches between four modes at random
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= $urandom_range(0, 3);
            sink_left <= $urandom_range(20, 120);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (sink_left % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // output item check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            hist.check_result(m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[32],
                              m_axis_tdata[33], m_axis_tdata[35:34], m_axis_tlast);
    end

    // watchdog on cycles with no item moving on either side
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, hist.pending());
        $display("Simulation FAILED");
        $finish;
    end

    // one command, sent in bursts with idle gaps in between
    task automatic send_command(input t_func func, input logic [PAGE_W-1:0] page_id);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page_id;
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        hist.note_command(func, page_id);
        func_seen[func]++;
        burst_left--;
        if (burst_left == 0) s_axis_tvalid <= 1'b0;
    endtask

    // mostly random pages, with the none page and the extremes now and then
    function automatic logic [PAGE_W-1:0] pick_page();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // visits past the ring depth, then walk all the way back and forward
    task automatic fill_and_walk();
        repeat (HIST_DEPTH + 4) send_command(FUNC_VISIT, $urandom | 32'd1);
        send_command(FUNC_LIST, $urandom);
        repeat (HIST_DEPTH + 1) send_command(FUNC_BACK, $urandom);
        send_command(FUNC_LIST, $urandom);
        repeat (HIST_DEPTH + 1) send_command(FUNC_NEXT, $urandom);
        send_command(FUNC_LIST, $urandom);
    endtask

    // runs of visits, backs and nexts with lists in between, plus stray commands
    task automatic random_commands(input int count);
        int sent;
        int pick;
        int run;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            run  = $urandom_range(1, 5);
            if (pick < 35) begin
                repeat (run) send_command(FUNC_VISIT, pick_page());
            end else if (pick < 55) begin
                repeat (run) send_command(FUNC_BACK, $urandom);
            end else if (pick < 75) begin
                repeat (run) send_command(FUNC_NEXT, $urandom);
            end else if (pick < 87) begin
                run = 1;
                send_command(FUNC_LIST, $urandom);
            end else begin
                run = 1;
                send_command(t_func'($urandom_range(0, 3)), $urandom);
            end
            sent += run;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty history, page zero and extreme page ids
        send_command(FUNC_LIST, 32'h0);
        send_command(FUNC_BACK, 32'h0);
        send_command(FUNC_NEXT, 32'h0);
        send_command(FUNC_VISIT, 32'h0);
        send_command(FUNC_LIST, 32'hFFFF_FFFF);
        send_command(FUNC_VISIT, 32'hFFFF_FFFF);
        send_command(FUNC_LIST, 32'h0);
        send_command(FUNC_BACK, 32'h0);
        send_command(FUNC_VISIT, 32'h1);
        send_command(FUNC_VISIT, 32'h8000_0000);
        send_command(FUNC_VISIT, 32'hAAAA_AAAA);
        send_command(FUNC_LIST, 32'h0);
        send_command(FUNC_BACK, 32'h0);
        send_command(FUNC_BACK, 32'h0);
        send_command(FUNC_BACK, 32'h0);
        send_command(FUNC_LIST, 32'h0);
        send_command(FUNC_NEXT, 32'h0);
        send_command(FUNC_LIST, 32'h0);
        send_command(FUNC_VISIT, 32'h0);
        send_command(FUNC_VISIT, 32'h5555_5555);
        send_command(FUNC_NEXT, 32'h0);
        send_command(FUNC_LIST, 32'h0);
        send_command(FUNC_BACK, 32'hFFFF_FFFF);
        send_command(FUNC_NEXT, 32'hFFFF_FFFF);

        fill_and_walk();
        random_commands(RANDOM_ITEMS);
        if (burst_left != 0) s_axis_tvalid <= 1'b0;

        // drain, then give the block time to show any stray output
        while (hist.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d visits, %0d backs, %0d nexts and %0d lists incl. a full ring",
                 func_seen[FUNC_VISIT], func_seen[FUNC_BACK], func_seen[FUNC_NEXT],
                 func_seen[FUNC_LIST]);
        $display("%0d output items compared, %0d mismatches", hist.checked, hist.errors);
        if (hist.errors == 0 && hist.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
